@@ rtl/button_click_gesture_detector_core_macros.svh @@
// Assertion macros shared by the button gesture detector RTL.
`ifndef BUTTON_CLICK_GESTURE_DETECTOR_CORE_MACROS_SVH
`define BUTTON_CLICK_GESTURE_DETECTOR_CORE_MACROS_SVH

`ifndef ASSERT_OFF

// Property checked on every rising edge of clk outside reset.
`define BCGD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition that must never be seen on a rising edge of clk outside reset.
`define BCGD_ASSERT_NEVER(lbl, cond, msg) \
	`BCGD_ASSERT(lbl, !(cond), msg)

`else

`define BCGD_ASSERT(lbl, prop, msg)
`define BCGD_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

@@ rtl/bcgd_pkg.sv @@
// Types and constants of the button gesture detector.
`default_nettype none

package bcgd_pkg;

	localparam int unsigned TimeW = 32;
	localparam int unsigned CountW = 32;
	localparam int unsigned CfgW = 16;
	localparam int unsigned CfgIdxW = 2;

	localparam logic            ActiveLowReset = 1'b1;
	localparam logic [CfgW-1:0] DebounceReset = 16'd20;
	localparam logic [CfgW-1:0] LongPressReset = 16'd1000;
	localparam logic [CfgW-1:0] DoubleClickReset = 16'd300;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_ACTIVE_LOW   = 2'd0,
		CFG_DEBOUNCE     = 2'd1,
		CFG_LONG_PRESS   = 2'd2,
		CFG_DOUBLE_CLICK = 2'd3
	} cfg_reg_t;

	typedef enum logic [2:0] {
		EV_NONE       = 3'd0,
		EV_PRESS_DOWN = 3'd1,
		EV_CLICK      = 3'd2,
		EV_DOUBLE     = 3'd3,
		EV_LONG       = 3'd4
	} event_t;

	typedef enum logic [3:0] {
		PH_IDLE     = 4'b0001,
		PH_DEBOUNCE = 4'b0010,
		PH_PRESSED  = 4'b0100,
		PH_WAIT     = 4'b1000
	} phase_t;

	typedef struct packed {
		logic             pin_level;
		logic [TimeW-1:0] time_ms;
		logic             clear_counts;
	} in_t;

	typedef struct packed {
		event_t            event_code;
		logic [CountW-1:0] click_total;
		logic [CountW-1:0] double_click_total;
		logic [CountW-1:0] long_press_total;
	} out_t;

endpackage

`default_nettype wire

@@ rtl/button_click_gesture_detector_core.sv @@
// Button gesture detector: debounce, click, double click and long press with event counters.
`default_nettype none

// The block takes one pin sample beat per clock and gives exactly one result beat for each.
// A sample passes an input register, the gesture state machine and counters evaluate it, and
// the result waits in an output register. The state machine update sets the rate at one beat
// per cycle; it holds only while the output side takes results. Elapsed times are taken
// modulo 2^32, so a timestamp that goes backwards reads as a very long wait. Configuration is
// written through the plain write port; the user must write it only while no beat is in
// flight, and the block itself does not enforce this.
`include "button_click_gesture_detector_core_macros.svh"

module button_click_gesture_detector_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire bcgd_pkg::in_t                 in_data,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output bcgd_pkg::out_t                     out_data,
	input  wire logic                          cfg_wr_en,
	input  wire logic [bcgd_pkg::CfgIdxW-1:0]  cfg_index,
	input  wire logic [bcgd_pkg::CfgW-1:0]     cfg_wdata
);
	import bcgd_pkg::*;

	logic            active_low_q;
	logic [CfgW-1:0] debounce_q;
	logic [CfgW-1:0] long_press_q;
	logic [CfgW-1:0] double_click_q;

	logic valid_s1;
	in_t  data_s1;
	logic advance;

	phase_t            phase_q, phase_d;
	logic [TimeW-1:0]  mark_time_q, mark_time_d;
	logic [TimeW-1:0]  press_time_q, press_time_d;
	logic              click_pending_q, click_pending_d;
	logic              double_confirmed_q, double_confirmed_d;
	logic [CountW-1:0] click_q, click_d;
	logic [CountW-1:0] double_q, double_d;
	logic [CountW-1:0] long_q, long_d;
	event_t            event_d;

	logic             pressed;
	logic [TimeW-1:0] since_mark;
	logic [TimeW-1:0] since_press;
	logic             debounce_done;
	logic             long_done;
	logic             window_done;

	logic out_valid_q;
	out_t out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_low_q   <= ActiveLowReset;
			debounce_q     <= DebounceReset;
			long_press_q   <= LongPressReset;
			double_click_q <= DoubleClickReset;
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_ACTIVE_LOW:   active_low_q   <= cfg_wdata[0];
				CFG_DEBOUNCE:     debounce_q     <= cfg_wdata;
				CFG_LONG_PRESS:   long_press_q   <= cfg_wdata;
				CFG_DOUBLE_CLICK: double_click_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// The input register moves on whenever the output register is free or being emptied.
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= in_data;
		end
	end

	assign pressed       = active_low_q ? !data_s1.pin_level : data_s1.pin_level;
	assign since_mark    = data_s1.time_ms - mark_time_q;
	assign since_press   = data_s1.time_ms - press_time_q;
	assign debounce_done = since_mark >= {{(TimeW-CfgW){1'b0}}, debounce_q};
	assign long_done     = since_press >= {{(TimeW-CfgW){1'b0}}, long_press_q};
	assign window_done   = since_mark >= {{(TimeW-CfgW){1'b0}}, double_click_q};

	always_comb begin
		phase_d            = phase_q;
		mark_time_d        = mark_time_q;
		press_time_d       = press_time_q;
		click_pending_d    = click_pending_q;
		double_confirmed_d = double_confirmed_q;
		click_d            = click_q;
		double_d           = double_q;
		long_d             = long_q;
		event_d            = EV_NONE;
		unique case (phase_q)
			PH_IDLE: begin
				if (pressed) begin
					phase_d     = PH_DEBOUNCE;
					mark_time_d = data_s1.time_ms;
				end
			end
			PH_DEBOUNCE: begin
				if (debounce_done) begin
					if (pressed) begin
						phase_d      = PH_PRESSED;
						press_time_d = data_s1.time_ms;
						event_d      = EV_PRESS_DOWN;
					end else begin
						phase_d = PH_IDLE;
					end
				end
			end
			PH_PRESSED: begin
				if (!pressed) begin
					priority if (long_done) begin
						long_d             = long_q + 1'b1;
						event_d            = EV_LONG;
						double_confirmed_d = 1'b0;
						click_pending_d    = 1'b0;
						phase_d            = PH_IDLE;
					end else if (double_confirmed_q) begin
						double_confirmed_d = 1'b0;
						click_pending_d    = 1'b0;
						phase_d            = PH_IDLE;
					end else begin
						phase_d         = PH_WAIT;
						mark_time_d     = data_s1.time_ms;
						click_pending_d = 1'b1;
					end
				end
			end
			PH_WAIT: begin
				if (pressed) begin
					if (click_pending_q) begin
						double_d           = double_q + 1'b1;
						click_pending_d    = 1'b0;
						double_confirmed_d = 1'b1;
						event_d            = EV_DOUBLE;
					end
					press_time_d = data_s1.time_ms;
					phase_d      = PH_PRESSED;
				end else if (window_done) begin
					if (click_pending_q) begin
						click_d         = click_q + 1'b1;
						event_d         = EV_CLICK;
						click_pending_d = 1'b0;
					end
					phase_d = PH_IDLE;
				end
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q            <= PH_IDLE;
			mark_time_q        <= '0;
			press_time_q       <= '0;
			click_pending_q    <= 1'b0;
			double_confirmed_q <= 1'b0;
			click_q            <= '0;
			double_q           <= '0;
			long_q             <= '0;
		end else if (advance) begin
			phase_q            <= phase_d;
			mark_time_q        <= mark_time_d;
			press_time_q       <= press_time_d;
			click_pending_q    <= click_pending_d;
			double_confirmed_q <= double_confirmed_d;
			click_q            <= data_s1.clear_counts ? '0 : click_d;
			double_q           <= data_s1.clear_counts ? '0 : double_d;
			long_q             <= data_s1.clear_counts ? '0 : long_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q.event_code         <= event_d;
			out_data_q.click_total        <= click_d;
			out_data_q.double_click_total <= double_d;
			out_data_q.long_press_total   <= long_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// A pending click and a confirmed double click exclude each other.
	`BCGD_ASSERT_NEVER(a_flags_exclusive, click_pending_q && double_confirmed_q,
		"pending click and confirmed double click both set")
	// A pending click lives only while waiting for the second press.
	`BCGD_ASSERT(a_pending_in_wait, !click_pending_q || (phase_q == PH_WAIT),
		"pending click outside the wait phase")
	// A confirmed double click lives only while the button is held.
	`BCGD_ASSERT(a_confirmed_in_pressed, !double_confirmed_q || (phase_q == PH_PRESSED),
		"confirmed double click outside the pressed phase")
	// A beat that asks for a clear leaves all counters at zero.
	`BCGD_ASSERT(a_clear_counts, (advance && data_s1.clear_counts) |=>
		(click_q == '0 && double_q == '0 && long_q == '0),
		"counters not cleared after a clearing beat")

endmodule

`default_nettype wire
